### src/pmms_pkg.sv
`timescale 1ns / 1ps
package pmms_pkg;

    // request selector codes
    localparam logic [1:0] RQ_POS  = 2'd0;
    localparam logic [1:0] RQ_VEL  = 2'd1;
    localparam logic [1:0] RQ_TICK = 2'd2;

    // configuration register indexes
    localparam logic CFG_HOME_X = 1'b0;
    localparam logic CFG_HOME_Y = 1'b1;

    localparam int AXES     = 3;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 192;
    localparam int SLEW_MUL = 10;

    typedef enum logic {
        DU_DIV  = 1'b0,
        DU_SQRT = 1'b1
    } t_du_op;

    typedef struct packed {
        logic   start;
        t_du_op op;
    } t_du_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_du_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### src/pmms_divsqrt.sv
`timescale 1ns / 1ps
module pmms_divsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmms_pkg::t_du_req i_req,
    input  logic [63:0]       i_x,
    input  logic [33:0]       i_d,
    output pmms_pkg::t_du_rsp o_rsp,
    output logic [63:0]       o_q
);
    import pmms_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_du_op      r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [35:0] r_rem;
    logic [63:0] r_q;
    logic [33:0] r_d;

    logic [35:0] a;
    logic [35:0] b;
    logic [36:0] sub;
    logic        ge;

    // one shared subtract and compare: a quotient bit or a root bit per cycle
    always_comb begin
        if (r_op == DU_SQRT) begin
            a = {r_rem[33:0], r_x[63:62]};
            b = {r_q[33:0], 2'b01};
        end else begin
            a = {r_rem[34:0], r_x[63]};
            b = {2'b00, r_d};
        end
        sub = {1'b0, a} - {1'b0, b};
        ge  = ~sub[36];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= DU_DIV;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == DU_SQRT) ? 6'd31 : 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_x;
            r_d   <= i_d;
            r_rem <= 36'd0;
            r_q   <= 64'd0;
        end else if (r_busy) begin
            r_rem <= ge ? sub[35:0] : a;
            r_q   <= {r_q[62:0], ge};
            r_x   <= (r_op == DU_SQRT) ? {r_x[61:0], 2'b00} : {r_x[62:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_q        = r_q;

endmodule

### src/pmms_mul.sv
`timescale 1ns / 1ps
module pmms_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

### src/point_mass_motion_step_top.sv
`timescale 1ns / 1ps
// Three-axis point-mass simulator on a stream interface. Position and velocity
// commands (tuser selector) give no item; the first tick after reset only primes
// the block, and each later tick gives one item with position and velocity. A
// position-mode tick with a zero offset or an expired countdown skips the root
// and the divides. A full position-mode tick is paced by the shared bit-serial
// divide/root unit: the distance root (32 root steps), the speed divide (64
// quotient steps) and the three component divides. The one shared 32x32
// multiplier serves the squares, the scaling and the integration. The block
// takes no item while a tick is being worked. A finished item waits in an output
// register while commands are taken. A tick that finishes while the previous
// item is still waiting holds in its last step until that item is taken.
module point_mass_motion_step_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // target_x, target_y, target_z, duration, is_relative, delta_time, zero pad
    input  logic [pmms_pkg::IN_W-1:0] i_s_tdata,
    // req_type
    input  logic [1:0]                i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [pmms_pkg::OUT_W-1:0] o_m_tdata,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_addr,
    input  logic [31:0]               i_cfg_wdata
);
    import pmms_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_OFS   = 12'b000000000010,
        S_SQ    = 12'b000000000100,
        S_SQACC = 12'b000000001000,
        S_SQRT  = 12'b000000010000,
        S_SPD   = 12'b000000100000,
        S_CMUL  = 12'b000001000000,
        S_CDIV  = 12'b000010000000,
        S_VEL   = 12'b000100000000,
        S_PMUL  = 12'b001000000000,
        S_PACC  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state;
    logic   r_go;
    logic [1:0] r_idx;
    logic   r_primed;
    logic   r_mode_pos;
    logic [23:0] r_tr;
    logic [15:0] r_dt;
    logic signed [31:0] r_pos  [AXES];
    logic signed [31:0] r_vel  [AXES];
    logic signed [31:0] r_gpos [AXES];
    logic signed [31:0] r_gvel [AXES];
    logic signed [31:0] r_want [AXES];
    logic signed [32:0] r_dlt  [AXES];
    logic [31:0] r_dmag [AXES];
    logic [33:0] r_l1;
    logic        r_s;
    logic [63:0] r_sq;
    logic [30:0] r_speed;
    logic        r_ovalid;
    logic [OUT_W-1:0] r_odata;

    // input fields
    logic signed [31:0] in_t [AXES];
    logic [23:0] in_dur;
    logic        in_rel;
    logic [15:0] in_dt;
    logic        in_acc;

    assign in_t[0] = i_s_tdata[31:0];
    assign in_t[1] = i_s_tdata[63:32];
    assign in_t[2] = i_s_tdata[95:64];
    assign in_dur  = i_s_tdata[119:96];
    assign in_rel  = i_s_tdata[120];
    assign in_dt   = i_s_tdata[136:121];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_tvalid && o_s_tready;

    // shared units
    t_du_req     du_req;
    t_du_rsp     du_rsp;
    logic [63:0] du_x;
    logic [33:0] du_d;
    logic [63:0] du_q;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    pmms_divsqrt u_du (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .i_x     (du_x),
        .i_d     (du_d),
        .o_rsp   (du_rsp),
        .o_q     (du_q)
    );

    pmms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // combinational helpers
    logic signed [32:0] n_dlt  [AXES];
    logic [31:0]        n_dmag [AXES];
    logic [33:0]        n_l1;
    logic [31:0]        n_mx;
    logic signed [31:0] n_vel  [AXES];
    logic signed [31:0] n_gpos [AXES];
    logic [19:0]        lim;
    logic [32:0]        root_len;
    logic [34:0]        dist3;
    logic [31:0]        vmag;
    logic [63:0]        pq;
    logic signed [65:0] pqs;
    logic [30:0]        comp;

    always_comb begin
        logic signed [33:0] diff;
        logic signed [33:0] slim;
        n_l1 = 34'd0;
        n_mx = 32'd0;
        lim  = 20'(r_dt) * 20'(SLEW_MUL);
        slim = $signed({14'd0, lim});
        for (int i = 0; i < AXES; i++) begin
            n_dlt[i]  = 33'(r_gpos[i]) - 33'(r_pos[i]);
            n_dmag[i] = n_dlt[i][32] ? 32'(-n_dlt[i]) : n_dlt[i][31:0];
            n_l1      = n_l1 + 34'(n_dmag[i]);
            if (n_dmag[i] > n_mx) begin
                n_mx = n_dmag[i];
            end
            n_gpos[i] = in_rel ? sat32(66'(in_t[i]) + 66'(r_pos[i])) : in_t[i];
            diff = 34'(r_want[i]) - 34'(r_vel[i]);
            if (diff > slim) begin
                diff = slim;
            end
            if (diff < -slim) begin
                diff = -slim;
            end
            n_vel[i] = sat32(66'(r_vel[i]) + 66'(diff));
        end
        root_len = 33'(du_q[31:0]) << r_s;
        dist3    = 35'(root_len) + (35'(root_len) << 1);
        vmag  = r_vel[r_idx][31] ? 32'(-33'(r_vel[r_idx])) : r_vel[r_idx];
        pq    = mul_p >> FRAC_BITS;
        pqs   = $signed({2'b00, pq});
        comp  = du_q[30:0];
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_SQ, S_SQACC: begin
                mul_a = r_dmag[r_idx] >> r_s;
                mul_b = r_dmag[r_idx] >> r_s;
            end
            S_CMUL, S_CDIV: begin
                mul_a = r_dmag[r_idx];
                mul_b = {1'b0, r_speed};
            end
            S_PMUL, S_PACC: begin
                mul_a = vmag;
                mul_b = 32'(r_dt);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        du_req.start = 1'b0;
        du_req.op    = DU_DIV;
        du_x         = 64'd0;
        du_d         = 34'd0;
        case (r_state)
            S_SQRT: begin
                du_req.start = r_go;
                du_req.op    = DU_SQRT;
                du_x         = r_sq;
            end
            S_SPD: begin
                du_req.start = r_go;
                du_x         = 64'(dist3) << FRAC_BITS;
                du_d         = 34'(r_tr);
            end
            S_CDIV: begin
                du_req.start = r_go;
                du_x         = mul_p;
                du_d         = r_l1;
            end
            default: begin
                du_req.start = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_go       <= 1'b0;
            r_idx      <= 2'd0;
            r_primed   <= 1'b0;
            r_mode_pos <= 1'b0;
            r_tr       <= 24'd0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_pos[i]  <= 32'sd0;
                r_vel[i]  <= 32'sd0;
                r_gpos[i] <= 32'sd0;
                r_gvel[i] <= 32'sd0;
            end
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_HOME_X) begin
                    r_pos[0] <= i_cfg_wdata;
                end else begin
                    r_pos[1] <= i_cfg_wdata;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_s_tuser)
                            RQ_POS: begin
                                r_mode_pos <= 1'b1;
                                r_tr       <= in_dur;
                                for (int i = 0; i < AXES; i++) begin
                                    r_gpos[i] <= n_gpos[i];
                                end
                            end
                            RQ_VEL: begin
                                r_mode_pos <= 1'b0;
                                r_tr       <= in_dur;
                                for (int i = 0; i < AXES; i++) begin
                                    r_gvel[i] <= in_t[i];
                                end
                            end
                            RQ_TICK: begin
                                if (!r_primed) begin
                                    r_primed <= 1'b1;
                                end else begin
                                    r_dt  <= in_dt;
                                    r_tr  <= (r_tr > 24'(in_dt)) ? r_tr - 24'(in_dt) : 24'd0;
                                    r_idx <= 2'd0;
                                    if (r_mode_pos) begin
                                        r_state <= S_OFS;
                                    end else begin
                                        for (int i = 0; i < AXES; i++) begin
                                            r_want[i] <= r_gvel[i];
                                        end
                                        r_state <= S_VEL;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_OFS: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_dlt[i]  <= n_dlt[i];
                        r_dmag[i] <= n_dmag[i];
                    end
                    r_l1 <= n_l1;
                    // when any offset is 2^31 or more, all offsets are halved before squaring
                    r_s  <= n_mx[31];
                    r_sq <= 64'd0;
                    if (n_l1 == 34'd0 || r_tr == 24'd0) begin
                        for (int i = 0; i < AXES; i++) begin
                            r_want[i] <= 32'sd0;
                        end
                        r_state <= S_VEL;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    r_sq <= r_sq + mul_p;
                    if (r_idx == 2'd2) begin
                        r_idx   <= 2'd0;
                        r_go    <= 1'b1;
                        r_state <= S_SQRT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: begin
                    r_go <= 1'b0;
                    if (du_rsp.done) begin
                        r_go    <= 1'b1;
                        r_state <= S_SPD;
                    end
                end
                S_SPD: begin
                    r_go <= 1'b0;
                    if (du_rsp.done) begin
                        r_speed <= (|du_q[63:31]) ? 31'h7fffffff : du_q[30:0];
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    r_go    <= 1'b1;
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    r_go <= 1'b0;
                    if (du_rsp.done) begin
                        r_want[r_idx] <= r_dlt[r_idx][32] ? -32'(comp) : 32'(comp);
                        if (r_idx == 2'd2) begin
                            r_idx   <= 2'd0;
                            r_state <= S_VEL;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_VEL: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_vel[i] <= n_vel[i];
                    end
                    r_idx   <= 2'd0;
                    r_state <= S_PMUL;
                end
                S_PMUL: begin
                    r_state <= S_PACC;
                end
                S_PACC: begin
                    // truncation toward zero: scale the magnitude, then apply the sign
                    r_pos[r_idx] <= r_vel[r_idx][31]
                        ? sat32(66'(r_pos[r_idx]) - pqs)
                        : sat32(66'(r_pos[r_idx]) + pqs);
                    if (r_idx == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_PMUL;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
            r_odata <= {r_vel[2], r_vel[1], r_vel[0], r_pos[2], r_pos[1], r_pos[0]};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

`ifndef SYNTHESIS
    a_unit_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_rsp.busy |-> (r_state == S_SQRT || r_state == S_SPD || r_state == S_CDIV))
        else $error("divide/root unit busy outside a waiting state");

    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tuser == RQ_TICK && r_primed) |=> !o_s_tready)
        else $error("primed tick did not start the sequencer");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("output item raised outside the output step");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import pmms_pkg::*;

    localparam logic [1:0] RQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 400;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] tgt [3];
        logic [23:0]        dur;
        logic               rel;
        logic [15:0]        dt;
        bit                 drain;
    } t_motion_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata = '0;
    logic [1:0]           i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_addr = 1'b0;
    logic [31:0]          i_cfg_wdata = '0;

    t_motion_req      pending_reqs[$];
    t_motion_req      cur_req;
    logic [OUT_W-1:0] expected_states[$];
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               errors = 0;
    int               cycles = 0;

    // shadow of the block state
    longint          sh_pos [3];
    longint          sh_vel [3];
    longint          sh_gpos [3];
    longint          sh_gvel [3];
    longint unsigned sh_trem;
    bit              sh_pmode;
    bit              sh_primed;

    point_mass_motion_step_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic apply_request(t_motion_req r);
        longint want [3];
        longint d [3];
        longint unsigned l1, mx, sq, root_len, speed, c, m, q;
        longint lim, diff, p;
        int s;
        logic [OUT_W-1:0] res;
        if (r.req == RQ_POS) begin
            sh_pmode = 1;
            for (int i = 0; i < 3; i++)
                sh_gpos[i] = r.rel ? clamp32(longint'(r.tgt[i]) + sh_pos[i]) : longint'(r.tgt[i]);
            sh_trem = r.dur;
        end else if (r.req == RQ_VEL) begin
            sh_pmode = 0;
            for (int i = 0; i < 3; i++) sh_gvel[i] = r.tgt[i];
            sh_trem = r.dur;
        end else if (r.req == RQ_TICK) begin
            if (!sh_primed) begin
                sh_primed = 1;
            end else begin
                lim = 10 * longint'(r.dt);
                sh_trem = (sh_trem > r.dt) ? sh_trem - r.dt : 0;
                for (int i = 0; i < 3; i++) want[i] = 0;
                if (sh_pmode) begin
                    l1 = 0;
                    mx = 0;
                    for (int i = 0; i < 3; i++) begin
                        d[i] = sh_gpos[i] - sh_pos[i];
                        l1 += magnitude(d[i]);
                        if (magnitude(d[i]) > mx) mx = magnitude(d[i]);
                    end
                    if (l1 != 0 && sh_trem != 0) begin
                        s = 0;
                        sq = 0;
                        while ((mx >> s) >= 64'h80000000) s++;
                        for (int i = 0; i < 3; i++) begin
                            m = magnitude(d[i]) >> s;
                            sq += m * m;
                        end
                        root_len = floor_root(sq) << s;
                        speed = ((3 * root_len) << 16) / sh_trem;
                        if (speed > 64'd2147483647) speed = 64'd2147483647;
                        for (int i = 0; i < 3; i++) begin
                            c = (magnitude(d[i]) * speed) / l1;
                            want[i] = (d[i] < 0) ? -longint'(c) : longint'(c);
                        end
                    end
                end else begin
                    for (int i = 0; i < 3; i++) want[i] = sh_gvel[i];
                end
                for (int i = 0; i < 3; i++) begin
                    diff = want[i] - sh_vel[i];
                    if (diff > lim) diff = lim;
                    if (diff < -lim) diff = -lim;
                    sh_vel[i] = clamp32(sh_vel[i] + diff);
                    p = sh_vel[i] * longint'(r.dt);
                    q = magnitude(p) >> 16;
                    sh_pos[i] = clamp32(sh_pos[i] + ((p < 0) ? -longint'(q) : longint'(q)));
                    res[32*i +: 32] = sh_pos[i][31:0];
                    res[96 + 32*i +: 32] = sh_vel[i][31:0];
                end
                expected_states.push_back(res);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) apply_request(cur_req);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(pending_reqs[0].drain && expected_states.size() != 0)) begin
                    cur_req = pending_reqs.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= cur_req.req;
                    i_s_tdata <= {7'd0, cur_req.dt, cur_req.rel, cur_req.dur,
                                  cur_req.tgt[2], cur_req.tgt[1], cur_req.tgt[0]};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] exp_res;
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                exp_res = expected_states.pop_front();
                for (int f = 0; f < 6; f++)
                    if (o_m_tdata[32*f +: 32] !== exp_res[32*f +: 32]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                                 exp_res[32*f +: 32], o_m_tdata[32*f +: 32]);
                        errors++;
                    end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_motion_req mk_req(logic [1:0] req, logic signed [31:0] x,
                                           logic signed [31:0] y, logic signed [31:0] z,
                                           logic [23:0] dur, logic rel, logic [15:0] dt);
        t_motion_req r;
        r.req = req;
        r.tgt[0] = x;
        r.tgt[1] = y;
        r.tgt[2] = z;
        r.dur = dur;
        r.rel = rel;
        r.dt = dt;
        r.drain = 0;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_target();
        if ($urandom_range(0, 9) < 7) return $signed($urandom_range(0, 32'h7fffff)) - 32'sh400000;
        return $urandom;
    endfunction

    function automatic t_motion_req rand_req();
        int k;
        logic [1:0] req;
        logic [23:0] dur;
        logic [15:0] dt;
        k = $urandom_range(0, 99);
        req = (k < 50) ? RQ_TICK : (k < 72) ? RQ_POS : (k < 96) ? RQ_VEL : RQ_NONE;
        k = $urandom_range(0, 9);
        dur = (k < 7) ? 24'($urandom_range(24'h4000, 24'h100000)) : (k < 8) ? 24'd0 : 24'($urandom);
        dt = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(16'h200, 16'h4000)) : 16'($urandom);
        return mk_req(req, rand_target(), rand_target(), rand_target(), dur, 1'($urandom), dt);
    endfunction

    task automatic write_home(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_pos[idx] = $signed(val);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_states.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        t_motion_req r;
        for (int i = 0; i < 3; i++) begin
            sh_pos[i] = 0;
            sh_vel[i] = 0;
            sh_gpos[i] = 0;
            sh_gvel[i] = 0;
        end
        sh_trem = 0;
        sh_pmode = 0;
        sh_primed = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_home(CFG_HOME_X, 32'h7fff0000);
        write_home(CFG_HOME_Y, 32'h80010000);

        send_idle_pct = 28;
        recv_idle_pct = 50;
        // commands before priming, then the priming tick
        pending_reqs.push_back(mk_req(RQ_VEL, 32'sh7fffffff, 32'sh80000000, 32'sh10000,
                                      24'hffffff, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'hffff));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'hffff));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_NONE, -1, -1, -1, 24'hffffff, 1'b1, 16'hffff));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'hffff));
        // relative goal that saturates
        pending_reqs.push_back(mk_req(RQ_POS, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                      24'h10000, 1'b1, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'h8000));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'hffff));
        // absolute extremes, huge offsets
        pending_reqs.push_back(mk_req(RQ_POS, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                      24'd1, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_POS, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                      24'hffffff, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'd1));
        // expired countdown
        pending_reqs.push_back(mk_req(RQ_POS, 32'sh10000, 32'sh20000, -32'sh30000,
                                      24'd0, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'h1000));
        // zero offset
        pending_reqs.push_back(mk_req(RQ_POS, 0, 0, 0, 24'h20000, 1'b1, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'h1000));
        pending_reqs.push_back(mk_req(RQ_VEL, 32'sh80000000, 32'sh7fffffff, 0,
                                      24'd0, 1'b0, 16'd0));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'hffff));
        pending_reqs.push_back(mk_req(RQ_TICK, 0, 0, 0, 0, 1'b0, 16'hffff));
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 28 : 0;
            if (ph == 0) begin
                write_home(CFG_HOME_X, 32'h80000000);
                write_home(CFG_HOME_Y, 32'h7fffffff);
            end else if (ph == 1) begin
                write_home(CFG_HOME_X, 32'h0);
                write_home(CFG_HOME_Y, 32'h0);
            end else begin
                write_home(CFG_HOME_X, $urandom);
                write_home(CFG_HOME_Y, $urandom);
            end
            for (int n = 0; n < 145; n++) begin
                r = rand_req();
                r.drain = (n == 70);
                pending_reqs.push_back(r);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/pmms_pkg.sv
src/pmms_divsqrt.sv
src/pmms_mul.sv
src/point_mass_motion_step_top.sv
sim/tb_top.sv
